@@ src/speck128_256_ctr_cipher_unit_defines.svh @@
// ----------------------------------------------------------------------------
// SPECK 128/256 CTR cipher unit assertion macros
// Concurrent checks sampled on i_clk, reset through i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SPECK128_256_CTR_CIPHER_UNIT_DEFINES_SVH
`define SPECK128_256_CTR_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SPK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spk same-cycle check failed");

// next-cycle implication, off during reset
`define SPK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spk next-cycle check failed");

// condition that must hold in the cycle after a reset cycle
`define SPK_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("spk reset check failed");

`endif

@@ src/spk_pkg.sv @@
// ----------------------------------------------------------------------------
// SPECK 128/256 CTR package
// Widths, register indexes and the config and request records shared by the unit.
// ----------------------------------------------------------------------------
package spk_pkg;

    localparam int WORD_W     = 64;
    localparam int ROUNDS     = 34;
    localparam int ROT_KEY    = 8;
    localparam int ROT_DATA   = 3;
    localparam int RND_W      = $clog2(ROUNDS);
    localparam int BLK_BYTES  = 16;
    localparam int WORD_BYTES = 8;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0    = 3'd0,
        CFG_KEY1    = 3'd1,
        CFG_KEY2    = 3'd2,
        CFG_KEY3    = 3'd3,
        CFG_IV_LOW  = 3'd4,
        CFG_IV_HIGH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] key0;
        logic [WORD_W-1:0] key1;
        logic [WORD_W-1:0] key2;
        logic [WORD_W-1:0] key3;
        logic [WORD_W-1:0] iv_low;
        logic [WORD_W-1:0] iv_high;
    } t_cfg;

    typedef struct packed {
        logic                 first_block;
        logic [WORD_W-1:0]    data_low;
        logic [WORD_W-1:0]    data_high;
        logic [BLK_BYTES-1:0] byte_en;
        logic [CNT_W-1:0]     byte_count;
        logic                 last_block;
    } t_req;

endpackage

@@ src/spk_in_if.sv @@
// ----------------------------------------------------------------------------
// SPECK CTR request channel
// Valid/ready channel carrying one data block per request.
// ----------------------------------------------------------------------------
interface spk_in_if;
    import spk_pkg::*;

    logic              valid;
    logic              ready;
    logic              first_block;
    logic [WORD_W-1:0] data_low;
    logic [WORD_W-1:0] data_high;
    logic [CNT_W-1:0]  byte_count;
    logic              last_block;

    modport source (
        output valid, first_block, data_low, data_high, byte_count, last_block,
        input  ready
    );

    modport sink (
        input  valid, first_block, data_low, data_high, byte_count, last_block,
        output ready
    );
endinterface

@@ src/spk_out_if.sv @@
// ----------------------------------------------------------------------------
// SPECK CTR result channel
// Valid/ready channel carrying one processed block per request.
// ----------------------------------------------------------------------------
interface spk_out_if;
    import spk_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
    logic [CNT_W-1:0]  result_count;
    logic              result_last;

    modport source (
        output valid, result_low, result_high, result_count, result_last,
        input  ready
    );

    modport sink (
        input  valid, result_low, result_high, result_count, result_last,
        output ready
    );
endinterface

@@ src/speck128_256_ctr_cipher_unit.sv @@
// An accepted request passes through the queue, the 34 rounds and the result load.
// The single round unit runs one round per cycle and takes a new request only
//   once the last result is loaded; key expansion runs alongside the first block.
// Reset: synchronous, active low; clears config, queue, counter, state and result valid.
// ----------------------------------------------------------------------------
// SPECK 128/256 CTR cipher unit
// Configuration registers, request queue front end and round engine back end.
// ----------------------------------------------------------------------------
module speck128_256_ctr_cipher_unit
    import spk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spk_in_if.sink               i_req,
    spk_out_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;
    logic q_valid;
    logic q_ready;
    t_req q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY0:    r_cfg.key0    <= i_cfg_data;
                CFG_KEY1:    r_cfg.key1    <= i_cfg_data;
                CFG_KEY2:    r_cfg.key2    <= i_cfg_data;
                CFG_KEY3:    r_cfg.key3    <= i_cfg_data;
                CFG_IV_LOW:  r_cfg.iv_low  <= i_cfg_data;
                CFG_IV_HIGH: r_cfg.iv_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spk_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_req   (q_req)
    );

    spk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_req   (q_req),
        .i_cfg     (r_cfg),
        .o_rsp     (o_rsp)
    );

endmodule

@@ src/spk_front.sv @@
// ----------------------------------------------------------------------------
// SPECK CTR front end
// Accepts requests, derives per-byte enables and queues them for the core.
// ----------------------------------------------------------------------------
module spk_front
    import spk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spk_in_if.sink     i_req,
    output logic       o_q_valid,
    input  logic       i_q_ready,
    output t_req       o_q_req
);

    t_req              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_req              n_entry;
    logic              push;
    logic              pop;

    assign i_req.ready = (r_count != QCNT_W'(QDEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_count != '0);
    assign pop         = o_q_valid && i_q_ready;
    assign o_q_req     = r_q[r_rd_ptr];

    always_comb begin
        n_entry.first_block = i_req.first_block;
        n_entry.data_low    = i_req.data_low;
        n_entry.data_high   = i_req.data_high;
        n_entry.byte_count  = i_req.byte_count;
        n_entry.last_block  = i_req.last_block;
        for (int j = 0; j < BLK_BYTES; j++) begin
            n_entry.byte_en[j] = (CNT_W'(j) < i_req.byte_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ src/spk_back.sv @@
// ----------------------------------------------------------------------------
// SPECK CTR round engine
// Runs one round per cycle, expanding the key alongside on a first block,
// then masks the keystream onto the data and holds the result.
// ----------------------------------------------------------------------------
module spk_back
    import spk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    output logic       o_q_ready,
    input  t_req       i_q_req,
    input  t_cfg       i_cfg,
    spk_out_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_req              r_cur;
    logic [RND_W-1:0]  r_round;
    logic [WORD_W-1:0] r_x;
    logic [WORD_W-1:0] r_y;
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] r_la;
    logic [WORD_W-1:0] r_lb;
    logic [WORD_W-1:0] r_lc;
    logic [WORD_W-1:0] r_ctr;
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_mem [ROUNDS];
    logic              r_out_valid;
    logic [WORD_W-1:0] r_res_low;
    logic [WORD_W-1:0] r_res_high;
    logic [CNT_W-1:0]  r_res_count;
    logic              r_res_last;

    logic              pop;
    logic              last_round;
    logic              out_load;
    logic              rd_en;
    logic [RND_W-1:0]  rd_addr;
    logic [WORD_W-1:0] ctr_base;
    logic [WORD_W-1:0] rk;
    logic [WORD_W-1:0] x_nx;
    logic [WORD_W-1:0] y_nx;
    logic [WORD_W-1:0] l_nx;
    logic [WORD_W-1:0] key_nx;
    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;

    assign o_q_ready  = (r_state == S_IDLE);
    assign pop        = o_q_ready && i_q_valid;
    assign last_round = (r_round == RND_W'(ROUNDS - 1));
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign ctr_base   = i_q_req.first_block ? '0 : r_ctr;

    assign rd_en   = pop || ((r_state == S_RUN) && !last_round);
    assign rd_addr = pop ? '0 : r_round + RND_W'(1);

    assign rk     = r_cur.first_block ? r_key : r_rd_data;
    assign x_nx   = ({r_x[ROT_KEY-1:0], r_x[WORD_W-1:ROT_KEY]} + r_y) ^ rk;
    assign y_nx   = {r_y[WORD_W-ROT_DATA-1:0], r_y[WORD_W-1:WORD_W-ROT_DATA]} ^ x_nx;
    assign l_nx   = ({r_la[ROT_KEY-1:0], r_la[WORD_W-1:ROT_KEY]} + r_key)
                    ^ WORD_W'(r_round);
    assign key_nx = {r_key[WORD_W-ROT_DATA-1:0], r_key[WORD_W-1:WORD_W-ROT_DATA]} ^ l_nx;

    always_comb begin
        for (int j = 0; j < WORD_BYTES; j++) begin
            mask_lo[j*8 +: 8] = {8{r_cur.byte_en[j]}};
            mask_hi[j*8 +: 8] = {8{r_cur.byte_en[j + WORD_BYTES]}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (last_round) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && r_cur.first_block) begin
            r_mem[r_round] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur   <= i_q_req;
            r_x     <= i_cfg.iv_low;
            r_y     <= i_cfg.iv_high ^ ctr_base;
            r_key   <= i_cfg.key0;
            r_la    <= i_cfg.key1;
            r_lb    <= i_cfg.key2;
            r_lc    <= i_cfg.key3;
        end else if (r_state == S_RUN) begin
            r_x     <= x_nx;
            r_y     <= y_nx;
            r_key   <= key_nx;
            r_la    <= r_lb;
            r_lb    <= r_lc;
            r_lc    <= l_nx;
        end
        if (out_load) begin
            r_res_low   <= (r_cur.data_low ^ r_x) & mask_lo;
            r_res_high  <= (r_cur.data_high ^ r_y) & mask_hi;
            r_res_count <= r_cur.byte_count;
            r_res_last  <= r_cur.last_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_round <= '0;
                r_ctr   <= ctr_base + WORD_W'(1);
            end else if ((r_state == S_RUN) && !last_round) begin
                r_round <= r_round + RND_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_low   = r_res_low;
    assign o_rsp.result_high  = r_res_high;
    assign o_rsp.result_count = r_res_count;
    assign o_rsp.result_last  = r_res_last;

endmodule

@@ src/spk_checker.sv @@
// ----------------------------------------------------------------------------
// SPECK CTR port checker
// Watches the result channel of the cipher unit over time.
// ----------------------------------------------------------------------------
`include "speck128_256_ctr_cipher_unit_defines.svh"

module spk_checker
    import spk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spk_out_if.source  o_rsp
);

    logic [2*WORD_W+CNT_W:0] rsp_bits;
    logic                    rsp_short;
    logic                    rsp_empty;

    assign rsp_bits  = {o_rsp.result_low, o_rsp.result_high, o_rsp.result_count,
                        o_rsp.result_last};
    assign rsp_short = (o_rsp.result_count <= CNT_W'(WORD_BYTES));
    assign rsp_empty = (o_rsp.result_count == '0);

    `SPK_ASSERT_RST(a_rst_no_result, !o_rsp.valid)
    `SPK_ASSERT_NXT(a_hold_valid, o_rsp.valid && !o_rsp.ready, o_rsp.valid)
    `SPK_ASSERT_NXT(a_hold_data, o_rsp.valid && !o_rsp.ready, $stable(rsp_bits))
    `SPK_ASSERT_IMP(a_high_zeroed, o_rsp.valid && rsp_short, o_rsp.result_high == '0)
    `SPK_ASSERT_IMP(a_low_zeroed, o_rsp.valid && rsp_empty, o_rsp.result_low == '0)

endmodule

bind speck128_256_ctr_cipher_unit spk_checker u_spk_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_rsp   (o_rsp)
);

@@ sim/speck128_256_ctr_cipher_unit_tb.sv @@
// ----------------------------------------------------------------------------
// SPECK 128/256 CTR cipher unit testbench
// Drives data blocks over the request channel under fixed and random key and IV
// settings, predicts each keystream result in a local cipher model and checks
// every response field against it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module speck128_256_ctr_cipher_unit_tb;
    import spk_pkg::*;

    localparam int CFG_REGS       = 6;
    localparam int TARGET_BLOCKS  = 1550;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [WORD_W-1:0]    ALL_ONES    = {WORD_W{1'b1}};

    typedef struct packed {
        logic              first;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_blk_req;

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } t_blk_rsp;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;

    spk_in_if  req_if ();
    spk_out_if rsp_if ();

    speck128_256_ctr_cipher_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_blk_req          block_backlog [$];
    t_blk_rsp          cipher_due_q [$];
    logic [WORD_W-1:0] cfg_mirror [CFG_REGS];
    logic [WORD_W-1:0] sched_keys [ROUNDS];
    logic [WORD_W-1:0] ctr_mirror;
    bit                gaps_on;
    int                send_gap;
    int                stall_left;
    int                idle_cycles;
    int                errors;
    int                blocks_queued;
    t_blk_req          req_item;
    t_blk_req          req_seen;
    t_blk_rsp          rsp_want;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int s);
        return (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic void load_schedule();
        logic [WORD_W-1:0] lw [3];
        int                s;
        sched_keys[0] = cfg_mirror[CFG_KEY0];
        lw[0] = cfg_mirror[CFG_KEY1];
        lw[1] = cfg_mirror[CFG_KEY2];
        lw[2] = cfg_mirror[CFG_KEY3];
        for (int i = 0; i < ROUNDS - 1; i++) begin
            s = i % 3;
            lw[s] = (rotr(lw[s], ROT_KEY) + sched_keys[i]) ^ WORD_W'(i);
            sched_keys[i + 1] = rotl(sched_keys[i], ROT_DATA) ^ lw[s];
        end
    endfunction

    function automatic logic [WORD_W-1:0] lane_mask(input int n);
        if (n <= 0)
            return '0;
        if (n >= WORD_BYTES)
            return ALL_ONES;
        return (WORD_W'(1) << (8 * n)) - 1;
    endfunction

    function automatic t_blk_rsp ctr_crypt(input t_blk_req r);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        int                n;
        t_blk_rsp          o;
        if (r.first) begin
            load_schedule();
            ctr_mirror = '0;
        end
        x = cfg_mirror[CFG_IV_LOW];
        y = cfg_mirror[CFG_IV_HIGH] ^ ctr_mirror;
        for (int i = 0; i < ROUNDS; i++) begin
            x = (rotr(x, ROT_KEY) + y) ^ sched_keys[i];
            y = rotl(y, ROT_DATA) ^ x;
        end
        ctr_mirror = ctr_mirror + 1;
        n = r.cnt;
        if (n > BLK_BYTES)
            n = BLK_BYTES;
        o.lo   = (r.lo ^ x) & lane_mask(n);
        o.hi   = (r.hi ^ y) & lane_mask(n > WORD_BYTES ? n - WORD_BYTES : 0);
        o.cnt  = r.cnt;
        o.last = r.last;
        return o;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!gaps_on || p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void queue_block(input logic first, input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi, input int cnt,
                                        input logic last);
        t_blk_req r;
        r.first = first;
        r.lo    = lo;
        r.hi    = hi;
        r.cnt   = CNT_W'(cnt);
        r.last  = last;
        block_backlog.push_back(r);
        blocks_queued++;
    endfunction

    function automatic void queue_message(input int nblk);
        for (int b = 0; b < nblk; b++)
            queue_block(b == 0, rand_word(), rand_word(),
                        (b == nblk - 1) ? $urandom_range(1, BLK_BYTES) : BLK_BYTES,
                        b == nblk - 1);
    endfunction

    function automatic void queue_noise(input int nblk);
        for (int b = 0; b < nblk; b++)
            queue_block($urandom_range(0, 3) == 0, rand_word(), rand_word(),
                        $urandom_range(0, 31), $urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx < CFG_REGS)
            cfg_mirror[idx] = val;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_cfg(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                               input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                               input logic [WORD_W-1:0] ivl, input logic [WORD_W-1:0] ivh);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_IV_LOW, ivl);
        write_reg(CFG_IV_HIGH, ivh);
        end_writes();
    endtask

    task automatic drain();
        while (block_backlog.size() != 0 || req_if.valid || cipher_due_q.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                req_seen.first = req_if.first_block;
                req_seen.lo    = req_if.data_low;
                req_seen.hi    = req_if.data_high;
                req_seen.cnt   = req_if.byte_count;
                req_seen.last  = req_if.last_block;
                cipher_due_q.push_back(ctr_crypt(req_seen));
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (block_backlog.size() != 0) begin
                    req_item = block_backlog.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.first_block <= req_item.first;
                    req_if.data_low    <= req_item.lo;
                    req_if.data_high   <= req_item.hi;
                    req_if.byte_count  <= req_item.cnt;
                    req_if.last_block  <= req_item.last;
                    send_gap = pick_gap();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (cipher_due_q.size() == 0) begin
                    report_mismatch("unexpected result", rsp_if.result_low, '0);
                end else begin
                    rsp_want = cipher_due_q.pop_front();
                    if (rsp_if.result_low !== rsp_want.lo)
                        report_mismatch("result_low", rsp_if.result_low, rsp_want.lo);
                    if (rsp_if.result_high !== rsp_want.hi)
                        report_mismatch("result_high", rsp_if.result_high, rsp_want.hi);
                    if (rsp_if.result_count !== rsp_want.cnt)
                        report_mismatch("result_count", WORD_W'(rsp_if.result_count),
                                        WORD_W'(rsp_want.cnt));
                    if (rsp_if.result_last !== rsp_want.last)
                        report_mismatch("result_last", WORD_W'(rsp_if.result_last),
                                        WORD_W'(rsp_want.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.first_block = 1'b0;
        req_if.data_low    = '0;
        req_if.data_high   = '0;
        req_if.byte_count  = '0;
        req_if.last_block  = 1'b0;
        rsp_if.ready       = 1'b0;
        gaps_on            = 1'b1;
        errors             = 0;
        blocks_queued      = 0;
        ctr_mirror         = '0;
        for (int i = 0; i < CFG_REGS; i++)
            cfg_mirror[i] = '0;
        for (int i = 0; i < ROUNDS; i++)
            sched_keys[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero key and IV: data and byte count extremes
        program_cfg('0, '0, '0, '0, '0, '0);
        queue_block(1'b1, '0, '0, BLK_BYTES, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, BLK_BYTES, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, 1, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, WORD_BYTES, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, WORD_BYTES + 1, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, 0, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, 31, 1'b0);
        queue_block(1'b0, ALL_ONES, ALL_ONES, BLK_BYTES + 1, 1'b1);
        drain();

        // all-ones key and IV
        program_cfg(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        queue_block(1'b1, ALL_ONES, '0, BLK_BYTES, 1'b0);
        queue_block(1'b0, '0, ALL_ONES, 15, 1'b0);
        queue_block(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, BLK_BYTES, 1'b0);
        queue_block(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 7, 1'b1);
        drain();

        // key change holds until the next first block; IV change applies at once
        program_cfg(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                    64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                    64'h202e72656e6f6f70, 64'h65736f6874206e49);
        queue_block(1'b1, '0, '0, BLK_BYTES, 1'b0);
        drain();
        write_reg(CFG_KEY2, {$urandom, $urandom});
        end_writes();
        queue_block(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, BLK_BYTES, 1'b0);
        drain();
        write_reg(CFG_IV_HIGH, {$urandom, $urandom});
        write_reg(CFG_SPARE_A, ALL_ONES);
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        end_writes();
        queue_block(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, BLK_BYTES, 1'b0);
        queue_block(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 3, 1'b1);
        drain();

        while (blocks_queued < TARGET_BLOCKS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: program_cfg('0, '0, '0, '0, '0, '0);
                1: program_cfg(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                2: begin
                    write_reg(CFG_IV_LOW, rand_word());
                    write_reg(CFG_IV_HIGH, rand_word());
                    end_writes();
                    queue_block(1'b0, rand_word(), rand_word(), BLK_BYTES, 1'b0);
                end
                3: begin
                    write_reg(t_cfg_idx'($urandom_range(CFG_KEY0, CFG_KEY3)), rand_word());
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand_word());
                    end_writes();
                    queue_block(1'b0, rand_word(), rand_word(), BLK_BYTES, 1'b0);
                end
                default: program_cfg(rand_word(), rand_word(), rand_word(), rand_word(),
                                     rand_word(), rand_word());
            endcase
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 99) < 85)
                    queue_message($urandom_range(1, 10));
                else
                    queue_noise($urandom_range(1, 5));
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && cipher_due_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ speck128_256_ctr_cipher_unit.f @@
+incdir+src
src/spk_pkg.sv
src/spk_in_if.sv
src/spk_out_if.sv
src/spk_front.sv
src/spk_back.sv
src/speck128_256_ctr_cipher_unit.sv
src/spk_checker.sv
sim/speck128_256_ctr_cipher_unit_tb.sv
